### hdl/ftas_pkg.sv
// Shared constants, axial table and fixed-point helpers of the texture axis selector.
package ftas_pkg;

  localparam int unsigned FRAC_BITS_DEF = 12;
  localparam int unsigned IN_W          = 16;
  localparam int unsigned SQRT_STEPS    = 31;
  localparam int unsigned AX_ENTRIES    = 6;

  typedef logic signed [1:0] ax_t;

  localparam ax_t P = 2'sd1;
  localparam ax_t M = -2'sd1;
  localparam ax_t Z = 2'sd0;

  // [entry][normal, U, V][x, y, z], in units of 1.0
  localparam ax_t AX_TAB [AX_ENTRIES][3][3] = '{
    '{ '{Z, P, Z}, '{M, Z, Z}, '{Z, Z, M} },
    '{ '{Z, M, Z}, '{P, Z, Z}, '{Z, Z, M} },
    '{ '{M, Z, Z}, '{Z, Z, P}, '{Z, M, Z} },
    '{ '{P, Z, Z}, '{Z, Z, M}, '{Z, M, Z} },
    '{ '{Z, Z, P}, '{P, Z, Z}, '{Z, M, Z} },
    '{ '{Z, Z, M}, '{M, Z, Z}, '{Z, M, Z} }
  };

  // Status that leaves a normaliser alongside its result
  typedef struct packed {
    logic valid;
    logic zero;
  } ftas_stat_t;

  // Divide by 2^s, rounding half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned s);
    logic [63:0] mag;
    logic [63:0] res;
    mag = x[63] ? unsigned'(-x) : unsigned'(x);
    res = (mag + (64'd1 << (s - 1))) >> s;
    return x[63] ? -signed'(res) : signed'(res);
  endfunction

  // Clamp to the 16-bit signed range
  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    logic signed [15:0] res;
    if (x > 64'sd32767) begin
      res = 16'sh7fff;
    end else if (x < -64'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = signed'(x[15:0]);
    end
    return res;
  endfunction

endpackage

### hdl/ftas_norm.sv
// Pipelined vector normaliser: sum of squares, range shift, square root, three dividers.
module ftas_norm #(
  parameter int unsigned FRAC_BITS = ftas_pkg::FRAC_BITS_DEF,
  parameter int unsigned WW        = 16,
  parameter int unsigned SBW       = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [WW-1:0]         w_i [3],
  input  logic [SBW-1:0]               sb_i,
  output ftas_pkg::ftas_stat_t         stat_o,
  output logic signed [FRAC_BITS+2:0]  q_o [3],
  output logic [SBW-1:0]               sb_o
);
  import ftas_pkg::*;

  localparam int unsigned QW   = FRAC_BITS + 2;
  localparam int unsigned NW   = FRAC_BITS + 32;
  localparam int unsigned SQ   = SQRT_STEPS;
  localparam int unsigned XW   = 2 * SQ;
  localparam int unsigned REMW = SQ + 2;
  localparam int unsigned SW   = 2 * WW + 2;
  localparam int unsigned NS   = 4 + SQ + QW;
  localparam int unsigned CW   = SBW + 4;

  // carry: zero flag, component signs, sideband
  logic [CW-1:0] c_q [NS];
  logic          v_q [NS];
  logic [CW-1:0] c0_d;
  logic          zero_c;

  assign zero_c = (w_i[0] == '0) && (w_i[1] == '0) && (w_i[2] == '0);
  assign c0_d   = {zero_c, w_i[2][WW-1], w_i[1][WW-1], w_i[0][WW-1], sb_i};

  // Advance valid bits and carried data through every stage
  for (genvar g = 0; g < NS; g++) begin : g_carry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= (g == 0) ? valid_i : v_q[(g == 0) ? 0 : g - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[g] <= (g == 0) ? c0_d : c_q[(g == 0) ? 0 : g - 1];
      end
    end
  end

  // Stage 1: magnitudes and squares
  logic [WW-1:0]   mag_c    [3];
  logic [WW-1:0]   s1_mag_q [3];
  logic [2*WW-1:0] s1_sq_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = w_i[i][WW-1] ? unsigned'(-w_i[i]) : unsigned'(w_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_q[i] <= mag_c[i];
        s1_sq_q[i]  <= (2 * WW)'(mag_c[i]) * (2 * WW)'(mag_c[i]);
      end
    end
  end

  // Stage 2: sum of squares
  logic [SW-1:0] s2_s_q;
  logic [WW-1:0] s2_mag_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_s_q   <= SW'(s1_sq_q[0]) + SW'(s1_sq_q[1]) + SW'(s1_sq_q[2]);
      s2_mag_q <= s1_mag_q;
    end
  end

  // Stage 3: shift by pairs of bits until the top pair is occupied
  logic [XW-1:0] sh_c;
  logic [31:0]   wk_c [3];
  logic [XW-1:0] s3_sh_q;
  logic [SQ-1:0] s3_wk_q [3];

  always_comb begin
    sh_c = XW'(s2_s_q);
    for (int i = 0; i < 3; i++) begin
      wk_c[i] = 32'(s2_mag_q[i]);
    end
    for (int j = 4; j >= 0; j--) begin
      if ((sh_c >> (XW - 2 * (1 << j))) == '0) begin
        sh_c = sh_c << (2 * (1 << j));
        for (int i = 0; i < 3; i++) begin
          wk_c[i] = wk_c[i] << (1 << j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sh_q <= sh_c;
      for (int i = 0; i < 3; i++) begin
        s3_wk_q[i] <= wk_c[i][SQ-1:0];
      end
    end
  end

  // Square root, one result bit per stage
  logic [REMW-1:0] rt_rem_q  [SQ];
  logic [SQ-1:0]   rt_root_q [SQ];
  logic [XW-1:0]   rt_x_q    [SQ];
  logic [SQ-1:0]   rt_wk_q   [SQ][3];

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    logic [REMW-1:0] rem_in;
    logic [SQ-1:0]   root_in;
    logic [XW-1:0]   x_in;
    logic [SQ-1:0]   wk_in [3];
    logic [REMW+1:0] r2;
    logic [REMW+1:0] trial;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = s3_sh_q;
      assign wk_in   = s3_wk_q;
    end else begin : g_next
      assign rem_in  = rt_rem_q[g-1];
      assign root_in = rt_root_q[g-1];
      assign x_in    = rt_x_q[g-1];
      assign wk_in   = rt_wk_q[g-1];
    end

    assign r2    = {rem_in, x_in[XW-1-2*g -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r2 >= trial) begin
          rt_rem_q[g]  <= REMW'(r2 - trial);
          rt_root_q[g] <= {root_in[SQ-2:0], 1'b1};
        end else begin
          rt_rem_q[g]  <= REMW'(r2);
          rt_root_q[g] <= {root_in[SQ-2:0], 1'b0};
        end
        rt_x_q[g]  <= x_in;
        rt_wk_q[g] <= wk_in;
      end
    end
  end

  // Rounded division of each scaled magnitude by the root, one quotient bit per stage
  logic [SQ-1:0] dv_l_q   [QW+1];
  logic [SQ-1:0] dv_rem_q [QW+1][3];
  logic [QW-1:0] dv_low_q [QW+1][3];
  logic [QW-1:0] dv_qt_q  [QW+1][3];

  for (genvar g = 0; g <= QW; g++) begin : g_div
    if (g == 0) begin : g_init
      logic [NW-1:0] num [3];
      logic [SQ-1:0] len;
      assign len = rt_root_q[SQ-1];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          num[i] = (NW'(rt_wk_q[SQ-1][i]) << FRAC_BITS) + NW'(len >> 1);
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dv_l_q[0] <= len;
          for (int i = 0; i < 3; i++) begin
            dv_rem_q[0][i] <= SQ'(num[i][NW-1:QW]);
            dv_low_q[0][i] <= num[i][QW-1:0];
            dv_qt_q[0][i]  <= '0;
          end
        end
      end
    end else begin : g_step
      logic [SQ:0] r [3];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          r[i] = {dv_rem_q[g-1][i], dv_low_q[g-1][i][QW-g]};
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dv_l_q[g] <= dv_l_q[g-1];
          for (int i = 0; i < 3; i++) begin
            dv_low_q[g][i] <= dv_low_q[g-1][i];
            if (r[i] >= {1'b0, dv_l_q[g-1]}) begin
              dv_rem_q[g][i] <= SQ'(r[i] - {1'b0, dv_l_q[g-1]});
              dv_qt_q[g][i]  <= {dv_qt_q[g-1][i][QW-2:0], 1'b1};
            end else begin
              dv_rem_q[g][i] <= r[i][SQ-1:0];
              dv_qt_q[g][i]  <= {dv_qt_q[g-1][i][QW-2:0], 1'b0};
            end
          end
        end
      end
    end
  end

  // Restore signs on the quotients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_o[i] = c_q[NS-1][SBW+i] ? -signed'({1'b0, dv_qt_q[QW][i]})
                                :  signed'({1'b0, dv_qt_q[QW][i]});
    end
  end

  assign stat_o.valid = v_q[NS-1];
  assign stat_o.zero  = c_q[NS-1][CW-1];
  assign sb_o         = c_q[NS-1][SBW-1:0];

endmodule

### hdl/face_texture_axis_select_top.sv
// Top level of the face texture axis selector: template choice, projection, cross product.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | sink      | in_valid_i/in_stall_o  | uv_lock, normal xyz, stored U and V xyz
//   out     | source    | out_valid_o/out_stall_i| U xyz, V xyz
//
// One face per cycle while in_stall_o is low; vectors are Q4.12 at the default FRAC_BITS.
// The two normalisers each have a 31-stage square root and FRAC_BITS+3 stage dividers.
// Reset clears the valid bits only; there is no clearing pass.
// The whole pipeline holds only while a result waits in the output register, the
// downstream side stalls and the last stage is occupied; bubbles otherwise close up.
module face_texture_axis_select_top #(
  parameter int unsigned FRAC_BITS = ftas_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               uv_lock_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   normal_x_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   normal_y_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   normal_z_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   stored_u_x_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   stored_u_y_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   stored_u_z_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   stored_v_x_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   stored_v_y_i,
  input  logic signed [ftas_pkg::IN_W-1:0]   stored_v_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ftas_pkg::IN_W-1:0]   u_x_o,
  output logic signed [ftas_pkg::IN_W-1:0]   u_y_o,
  output logic signed [ftas_pkg::IN_W-1:0]   u_z_o,
  output logic signed [ftas_pkg::IN_W-1:0]   v_x_o,
  output logic signed [ftas_pkg::IN_W-1:0]   v_y_o,
  output logic signed [ftas_pkg::IN_W-1:0]   v_z_o
);
  import ftas_pkg::*;

  localparam int unsigned NQW  = FRAC_BITS + 3;
  localparam int unsigned TW   = (FRAC_BITS + 2 > IN_W) ? FRAC_BITS + 2 : IN_W;
  localparam int unsigned BW   = TW + 1;
  localparam int unsigned DW   = TW + 2;
  localparam int unsigned PW   = TW + 3;
  localparam int unsigned CPW  = TW + NQW;
  localparam int unsigned SUMW = CPW + 2;
  localparam int unsigned MW   = NQW + DW;
  localparam int unsigned XPW  = 2 * NQW;
  localparam int unsigned SB1W = 6 * TW;
  localparam int unsigned SB2W = 1 + 3 * NQW + 6 * TW;
  localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
  localparam logic signed [BW-1:0] ONE_B = BW'(1) << FRAC_BITS;

  function automatic logic signed [TW-1:0] ax_val(input ax_t c);
    logic signed [TW-1:0] res;
    if (c == P) begin
      res = ONE_T;
    end else if (c == M) begin
      res = -ONE_T;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic logic signed [BW-1:0] ax_mul(input ax_t c,
                                                  input logic signed [IN_W-1:0] x);
    logic signed [BW-1:0] res;
    if (c == P) begin
      res = BW'(x);
    end else if (c == M) begin
      res = -BW'(x);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  logic en;
  logic g_v_q;
  logic out_valid_q;

  // Freeze only when the last stage cannot move into the output register
  assign en         = !(g_v_q && out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Input register
  logic                  in_v_q;
  logic                  in_lock_q;
  logic signed [IN_W-1:0] in_n_q  [3];
  logic signed [IN_W-1:0] in_su_q [3];
  logic signed [IN_W-1:0] in_sv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_lock_q  <= uv_lock_i;
      in_n_q[0]  <= normal_x_i;
      in_n_q[1]  <= normal_y_i;
      in_n_q[2]  <= normal_z_i;
      in_su_q[0] <= stored_u_x_i;
      in_su_q[1] <= stored_u_y_i;
      in_su_q[2] <= stored_u_z_i;
      in_sv_q[0] <= stored_v_x_i;
      in_sv_q[1] <= stored_v_y_i;
      in_sv_q[2] <= stored_v_z_i;
    end
  end

  // Pick the templates: stored axes under lock when both are nonzero, else the best axial entry
  logic                   keep_c;
  logic [2:0]             best_c;
  logic signed [TW-1:0]   tu_c [3];
  logic signed [TW-1:0]   tv_c [3];

  always_comb begin
    logic signed [BW-1:0] best_dot;
    logic signed [BW-1:0] d;
    keep_c = in_lock_q
          && ((in_su_q[0] != '0) || (in_su_q[1] != '0) || (in_su_q[2] != '0))
          && ((in_sv_q[0] != '0) || (in_sv_q[1] != '0) || (in_sv_q[2] != '0));
    best_c   = '0;
    best_dot = -ONE_B;
    for (int e = 0; e < AX_ENTRIES; e++) begin
      d = ax_mul(AX_TAB[e][0][0], in_n_q[0]) + ax_mul(AX_TAB[e][0][1], in_n_q[1])
        + ax_mul(AX_TAB[e][0][2], in_n_q[2]);
      if (d > best_dot) begin
        best_dot = d;
        best_c   = 3'(e);
      end
    end
    for (int i = 0; i < 3; i++) begin
      tu_c[i] = keep_c ? TW'(in_su_q[i]) : ax_val(AX_TAB[best_c][1][i]);
      tv_c[i] = keep_c ? TW'(in_sv_q[i]) : ax_val(AX_TAB[best_c][2][i]);
    end
  end

  // Normalise the face normal
  ftas_stat_t              n1_stat;
  logic signed [NQW-1:0]   n1_q [3];
  logic [SB1W-1:0]         n1_sb;
  logic signed [TW-1:0]    n1_tu [3];
  logic signed [TW-1:0]    n1_tv [3];

  ftas_norm #(
    .FRAC_BITS (FRAC_BITS),
    .WW        (IN_W),
    .SBW       (SB1W)
  ) u_norm_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .w_i     (in_n_q),
    .sb_i    ({tu_c[0], tu_c[1], tu_c[2], tv_c[0], tv_c[1], tv_c[2]}),
    .stat_o  (n1_stat),
    .q_o     (n1_q),
    .sb_o    (n1_sb)
  );

  assign {n1_tu[0], n1_tu[1], n1_tu[2], n1_tv[0], n1_tv[1], n1_tv[2]} = n1_sb;

  // Stage C: template times normal
  logic                  c_v_q;
  logic                  c_z_q;
  logic signed [CPW-1:0] c_prod_q [3];
  logic signed [NQW-1:0] c_nh_q   [3];
  logic signed [TW-1:0]  c_tu_q   [3];
  logic signed [TW-1:0]  c_tv_q   [3];

  // Stage D: dot product
  logic                  d_v_q;
  logic                  d_z_q;
  logic signed [DW-1:0]  d_dot_q;
  logic signed [NQW-1:0] d_nh_q [3];
  logic signed [TW-1:0]  d_tu_q [3];
  logic signed [TW-1:0]  d_tv_q [3];

  // Stage E: normal times dot
  logic                  e_v_q;
  logic                  e_z_q;
  logic signed [MW-1:0]  e_m_q  [3];
  logic signed [NQW-1:0] e_nh_q [3];
  logic signed [TW-1:0]  e_tu_q [3];
  logic signed [TW-1:0]  e_tv_q [3];

  // Stage F: projection onto the face plane
  logic                  f_v_q;
  logic                  f_z_q;
  logic signed [PW-1:0]  f_p_q  [3];
  logic signed [NQW-1:0] f_nh_q [3];
  logic signed [TW-1:0]  f_tu_q [3];
  logic signed [TW-1:0]  f_tv_q [3];

  logic signed [SUMW-1:0] dot_sum_c;
  assign dot_sum_c = SUMW'(c_prod_q[0]) + SUMW'(c_prod_q[1]) + SUMW'(c_prod_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= n1_stat.valid;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_z_q  <= n1_stat.zero;
      c_nh_q <= n1_q;
      c_tu_q <= n1_tu;
      c_tv_q <= n1_tv;
      for (int i = 0; i < 3; i++) begin
        c_prod_q[i] <= CPW'(n1_tu[i]) * CPW'(n1_q[i]);
      end

      d_z_q   <= c_z_q;
      d_nh_q  <= c_nh_q;
      d_tu_q  <= c_tu_q;
      d_tv_q  <= c_tv_q;
      d_dot_q <= DW'(rnd_shift(64'(dot_sum_c), FRAC_BITS));

      e_z_q  <= d_z_q;
      e_nh_q <= d_nh_q;
      e_tu_q <= d_tu_q;
      e_tv_q <= d_tv_q;
      for (int i = 0; i < 3; i++) begin
        e_m_q[i] <= MW'(d_nh_q[i]) * MW'(d_dot_q);
      end

      f_z_q  <= e_z_q;
      f_nh_q <= e_nh_q;
      f_tu_q <= e_tu_q;
      f_tv_q <= e_tv_q;
      for (int i = 0; i < 3; i++) begin
        f_p_q[i] <= PW'(e_tu_q[i]) - PW'(rnd_shift(64'(e_m_q[i]), FRAC_BITS));
      end
    end
  end

  // Normalise the projected U
  ftas_stat_t             n2_stat;
  logic signed [NQW-1:0]  n2_q [3];
  logic [SB2W-1:0]        n2_sb;
  logic                   n2_z1;
  logic signed [NQW-1:0]  n2_nh [3];
  logic signed [TW-1:0]   n2_tu [3];
  logic signed [TW-1:0]   n2_tv [3];

  ftas_norm #(
    .FRAC_BITS (FRAC_BITS),
    .WW        (PW),
    .SBW       (SB2W)
  ) u_norm_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v_q),
    .w_i     (f_p_q),
    .sb_i    ({f_z_q, f_nh_q[0], f_nh_q[1], f_nh_q[2],
               f_tu_q[0], f_tu_q[1], f_tu_q[2], f_tv_q[0], f_tv_q[1], f_tv_q[2]}),
    .stat_o  (n2_stat),
    .q_o     (n2_q),
    .sb_o    (n2_sb)
  );

  assign {n2_z1, n2_nh[0], n2_nh[1], n2_nh[2],
          n2_tu[0], n2_tu[1], n2_tu[2], n2_tv[0], n2_tv[1], n2_tv[2]} = n2_sb;

  // Stage G: cross product terms
  logic                  g_pass_q;
  logic signed [XPW-1:0] g_x_q  [6];
  logic signed [NQW-1:0] g_uh_q [3];
  logic signed [TW-1:0]  g_tu_q [3];
  logic signed [TW-1:0]  g_tv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (en) begin
      g_v_q <= n2_stat.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_pass_q <= n2_z1 || n2_stat.zero;
      g_uh_q   <= n2_q;
      g_tu_q   <= n2_tu;
      g_tv_q   <= n2_tv;
      g_x_q[0] <= XPW'(n2_q[1]) * XPW'(n2_nh[2]);
      g_x_q[1] <= XPW'(n2_q[2]) * XPW'(n2_nh[1]);
      g_x_q[2] <= XPW'(n2_q[2]) * XPW'(n2_nh[0]);
      g_x_q[3] <= XPW'(n2_q[0]) * XPW'(n2_nh[2]);
      g_x_q[4] <= XPW'(n2_q[0]) * XPW'(n2_nh[1]);
      g_x_q[5] <= XPW'(n2_q[1]) * XPW'(n2_nh[0]);
    end
  end

  // Finish V, choose pass-through, saturate
  logic signed [IN_W-1:0] res_u [3];
  logic signed [IN_W-1:0] res_v [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_u[i] = g_pass_q ? sat16(64'(g_tu_q[i])) : sat16(64'(g_uh_q[i]));
      res_v[i] = g_pass_q ? sat16(64'(g_tv_q[i]))
                          : sat16(rnd_shift(64'(g_x_q[2*i]) - 64'(g_x_q[2*i+1]),
                                            FRAC_BITS));
    end
  end

  // Output register
  logic                   out_valid_d;
  logic signed [IN_W-1:0] out_u_q [3];
  logic signed [IN_W-1:0] out_v_q [3];

  assign out_valid_d = (en && g_v_q) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && g_v_q) begin
      out_u_q <= res_u;
      out_v_q <= res_v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign u_x_o       = out_u_q[0];
  assign u_y_o       = out_u_q[1];
  assign u_z_o       = out_u_q[2];
  assign v_x_o       = out_v_q[0];
  assign v_y_o       = out_v_q[1];
  assign v_z_o       = out_v_q[2];

endmodule

### hdl/ftas_checker.sv
// Port-level checks of the texture axis selector, bound to its top level.
module ftas_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // Input stalls only while a result waits behind a downstream stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // Nothing leaves the pipeline straight after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result offered straight after reset");

endmodule

bind face_texture_axis_select_top ftas_checker u_ftas_checker (.*);
